// ===== sv/hsvrgb_pkg.sv =====
// Shared types, sector codes and the divide-by-255 helper for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned PROD_W  = 2 * CHAN_W;
    localparam int unsigned SECT_W  = 3;

    localparam logic [CHAN_W-1:0] FULL_SCALE  = 8'd255;
    localparam int unsigned       SECTOR_DEG  = 60;
    localparam int unsigned       SECTOR_NUM  = 6;
    localparam int unsigned       HUE_SECTORS = 8;
    localparam logic [15:0]       DIV255_RECIP = 16'h8081;

    typedef logic [SECT_W-1:0] sector_t;

    localparam sector_t SECTOR_RED_GREEN    = 3'd0;
    localparam sector_t SECTOR_GREEN_RED    = 3'd1;
    localparam sector_t SECTOR_GREEN_BLUE   = 3'd2;
    localparam sector_t SECTOR_BLUE_GREEN   = 3'd3;
    localparam sector_t SECTOR_BLUE_RED     = 3'd4;
    localparam sector_t SECTOR_RED_BLUE     = 3'd5;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        sector_t           sector;
        logic [CHAN_W-1:0] frac;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
    } sector_stage_t;

    typedef struct packed {
        sector_t           sector;
        logic [CHAN_W-1:0] val;
        logic [CHAN_W-1:0] p;
        logic [PROD_W-1:0] q_prod;
        logic [PROD_W-1:0] t_prod;
    } term_stage_t;

    // Floor division by 255 of a 16-bit value through a reciprocal multiply.
    // The reciprocal 0x8081 / 2^23 is exact over the whole 16-bit range; the 8-bit result holds quotients up to 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'(DIV255_RECIP);
        return prod[30:23];
    endfunction

endpackage

// ===== sv/hsvrgb_sector.sv =====
// First pipeline stage: hue sector and fraction within the sector.
module hsvrgb_sector (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  hsvrgb_pkg::hsv_t           in_data,
    output logic                       out_valid,
    output hsvrgb_pkg::sector_stage_t  out_data
);
    import hsvrgb_pkg::*;

    logic [3:0]        raw_sector;
    logic [HUE_W-1:0]  base;
    logic [HUE_W-1:0]  rem_wide;
    logic [5:0]        rem;
    logic [9:0]        rem_x17;
    sector_stage_t     data_next;
    sector_stage_t     data_reg;
    logic              valid_next;
    logic              valid_reg;

    always_comb
    begin
        raw_sector = 4'd0;
        for (int i = 1; i <= HUE_SECTORS; i++)
        begin
            if (in_data.hue >= HUE_W'(i * SECTOR_DEG))
            begin
                raw_sector = 4'(i);
            end
        end
        base     = HUE_W'(raw_sector * SECTOR_DEG);
        rem_wide = in_data.hue - base;
        rem      = rem_wide[5:0];
        // 255 / 60 reduces to 17 / 4, so the floor is a multiply and a shift.
        rem_x17  = 10'(rem) * 10'd17;

        if (raw_sector >= 4'(SECTOR_NUM))
        begin
            data_next.sector = SECT_W'(raw_sector - 4'(SECTOR_NUM));
        end
        else
        begin
            data_next.sector = SECT_W'(raw_sector);
        end
        data_next.frac = rem_x17[9:2];
        data_next.sat  = in_data.saturation;
        data_next.val  = in_data.brightness;
        valid_next     = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/hsvrgb_terms.sv =====
// Middle pipeline stages: products, divisions by 255 and the q and t products.
module hsvrgb_terms (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  hsvrgb_pkg::sector_stage_t  in_data,
    output logic                       out_valid,
    output hsvrgb_pkg::term_stage_t    out_data
);
    import hsvrgb_pkg::*;

    typedef struct packed {
        sector_t           sector;
        logic [CHAN_W-1:0] val;
        logic [PROD_W-1:0] fs;
        logic [PROD_W-1:0] nfs;
        logic [PROD_W-1:0] ps;
    } prod_stage_t;

    typedef struct packed {
        sector_t           sector;
        logic [CHAN_W-1:0] val;
        logic [CHAN_W-1:0] p;
        logic [CHAN_W-1:0] qa;
        logic [CHAN_W-1:0] ta;
    } div_stage_t;

    prod_stage_t  s2_next;
    prod_stage_t  s2_reg;
    div_stage_t   s3_next;
    div_stage_t   s3_reg;
    term_stage_t  s4_next;
    term_stage_t  s4_reg;
    logic [2:0]   valid_next;
    logic [2:0]   valid_reg;

    always_comb
    begin
        s2_next.sector = in_data.sector;
        s2_next.val    = in_data.val;
        s2_next.fs     = PROD_W'(in_data.frac) * PROD_W'(in_data.sat);
        s2_next.nfs    = PROD_W'(FULL_SCALE - in_data.frac) * PROD_W'(in_data.sat);
        s2_next.ps     = PROD_W'(FULL_SCALE - in_data.sat) * PROD_W'(in_data.val);

        s3_next.sector = s2_reg.sector;
        s3_next.val    = s2_reg.val;
        s3_next.p      = div255(s2_reg.ps);
        s3_next.qa     = FULL_SCALE - div255(s2_reg.fs);
        s3_next.ta     = FULL_SCALE - div255(s2_reg.nfs);

        s4_next.sector = s3_reg.sector;
        s4_next.val    = s3_reg.val;
        s4_next.p      = s3_reg.p;
        s4_next.q_prod = PROD_W'(s3_reg.qa) * PROD_W'(s3_reg.val);
        s4_next.t_prod = PROD_W'(s3_reg.ta) * PROD_W'(s3_reg.val);

        valid_next = {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
    end

    assign out_valid = valid_reg[2];
    assign out_data  = s4_reg;

endmodule

// ===== sv/hsvrgb_select.sv =====
// Last pipeline stage: final divisions and the channel permutation per sector.
module hsvrgb_select (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  hsvrgb_pkg::term_stage_t  in_data,
    output logic                     out_valid,
    output hsvrgb_pkg::rgb_t         out_data
);
    import hsvrgb_pkg::*;

    logic [CHAN_W-1:0] q;
    logic [CHAN_W-1:0] t;
    logic [CHAN_W-1:0] p;
    logic [CHAN_W-1:0] v;
    rgb_t              rgb_next;
    rgb_t              rgb_reg;
    logic              valid_next;
    logic              valid_reg;

    always_comb
    begin
        q = div255(in_data.q_prod);
        t = div255(in_data.t_prod);
        p = in_data.p;
        v = in_data.val;
        case (in_data.sector)
            SECTOR_RED_GREEN:  rgb_next = '{red: v, green: t, blue: p};
            SECTOR_GREEN_RED:  rgb_next = '{red: q, green: v, blue: p};
            SECTOR_GREEN_BLUE: rgb_next = '{red: p, green: v, blue: t};
            SECTOR_BLUE_GREEN: rgb_next = '{red: p, green: q, blue: v};
            SECTOR_BLUE_RED:   rgb_next = '{red: t, green: p, blue: v};
            SECTOR_RED_BLUE:   rgb_next = '{red: v, green: p, blue: q};
            default:           rgb_next = '{red: v, green: p, blue: q};
        endcase
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = rgb_reg;

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// Top level of the pipelined HSV to RGB converter.
// Usage: drive hsv with a hue of 0 to 360 degrees, a saturation and a brightness,
// and raise start for one cycle per item. An item is taken at every rising edge
// where start is high and busy is low. Since every stage advances each cycle,
// busy stays low, so one item may enter on every clock cycle.
// Each item produces one result on rgb, marked by done for exactly one cycle.
// An accepted item appears on rgb with done high once it has passed through
// each of the register stages, in the order that the next sentence lists them.
// Throughput is one item per cycle, set by the five register stages: sector and
// fraction, the three products, the divisions by 255, the q and t products, and
// the final divisions with the channel select.
// The receiver has no way to stall, so results are never held back.
// Reset clears the valid bits of all stages; items in flight are dropped and
// done stays low until new items reach the output.
module hsv_to_rgb_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  hsvrgb_pkg::hsv_t  hsv,
    output logic              done,
    output hsvrgb_pkg::rgb_t  rgb
);
    import hsvrgb_pkg::*;

    logic           accept;
    logic           s1_valid;
    sector_stage_t  s1_data;
    logic           s4_valid;
    term_stage_t    s4_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsvrgb_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (hsv),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    hsvrgb_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s4_valid),
        .out_data  (s4_data)
    );

    hsvrgb_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid),
        .in_data   (s4_data),
        .out_valid (done),
        .out_data  (rgb)
    );

`ifndef SYNTHESIS
    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted item did not produce a result after five cycles");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid |=> done)
        else $error("result strobe missing after last stage");

    a_black_in_black_out: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hsv.brightness == '0) |-> ##5 (rgb == '0))
        else $error("zero brightness did not give black");

    a_gray_when_unsaturated: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hsv.saturation == '0) |-> ##5
            (rgb.red == $past(hsv.brightness, 5) && rgb.green == rgb.red
             && rgb.blue == rgb.red))
        else $error("zero saturation did not give gray at the brightness level");
`endif

endmodule

// ===== tb/sv/tb_hsv_to_rgb_converter.sv =====
// Self-checking testbench for the HSV to RGB converter: directed corner colors, random colors and bursts.
module tb_hsv_to_rgb_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvrgb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    hsv_t hsv = '0;
    logic done;
    rgb_t rgb;

    rgb_t pending_rgb[$];
    int   fault_count = 0;
    int   colors_sent = 0;
    int   colors_checked = 0;

    hsv_to_rgb_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .hsv   (hsv),
        .done  (done),
        .rgb   (rgb)
    );

    always #1 clk = ~clk;

    function automatic rgb_t convert_color(hsv_t c);
        int unsigned full;
        int unsigned frac;
        int unsigned sat;
        int unsigned val;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        sector_t     sect;
        rgb_t        res;
        full = 32'(FULL_SCALE);
        sat  = 32'(c.saturation);
        val  = 32'(c.brightness);
        frac = (c.hue % SECTOR_DEG) * full / SECTOR_DEG;
        p    = ((full - sat) * val) / full;
        q    = ((full - (frac * sat) / full) * val) / full;
        t    = ((full - ((full - frac) * sat) / full) * val) / full;
        sect = sector_t'((c.hue / SECTOR_DEG) % SECTOR_NUM);
        case (sect)
            SECTOR_RED_GREEN:
            begin
                res.red = val[7:0]; res.green = t[7:0]; res.blue = p[7:0];
            end
            SECTOR_GREEN_RED:
            begin
                res.red = q[7:0]; res.green = val[7:0]; res.blue = p[7:0];
            end
            SECTOR_GREEN_BLUE:
            begin
                res.red = p[7:0]; res.green = val[7:0]; res.blue = t[7:0];
            end
            SECTOR_BLUE_GREEN:
            begin
                res.red = p[7:0]; res.green = q[7:0]; res.blue = val[7:0];
            end
            SECTOR_BLUE_RED:
            begin
                res.red = t[7:0]; res.green = p[7:0]; res.blue = val[7:0];
            end
            default:
            begin
                res.red = val[7:0]; res.green = p[7:0]; res.blue = q[7:0];
            end
        endcase
        return res;
    endfunction

    function automatic void report_fault(string what);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    // Accepted items are predicted at the accepting edge; results are checked in order.
    always @(posedge clk)
    begin
        rgb_t want;
        if (done)
        begin
            if (pending_rgb.size() == 0)
            begin
                report_fault($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                       rgb.red, rgb.green, rgb.blue));
            end
            else
            begin
                want = pending_rgb.pop_front();
                colors_checked++;
                if (rgb.red !== want.red || rgb.green !== want.green
                    || rgb.blue !== want.blue)
                begin
                    report_fault($sformatf(
                        "mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        want.red, want.green, want.blue, rgb.red, rgb.green, rgb.blue));
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            pending_rgb.push_back(convert_color(hsv));
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    task automatic send_color(hsv_t c, int gap);
        bit ready;
        start <= 1'b1;
        hsv   <= c;
        do
        begin
            @(negedge clk);
            ready = !busy;
            @(posedge clk);
        end while (!ready);
        colors_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            hsv   <= hsv_t'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_channel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 8'd0;
        end
        if (r == 1)
        begin
            return 8'd255;
        end
        return 8'($urandom);
    endfunction

    function automatic hsv_t random_color();
        hsv_t c;
        if ($urandom_range(0, 99) < 85)
        begin
            c.hue = 9'($urandom_range(0, 360));
        end
        else
        begin
            c.hue = 9'($urandom_range(361, 511));
        end
        c.saturation = pick_channel();
        c.brightness = pick_channel();
        return c;
    endfunction

    task automatic test_corner_colors();
        int   hues[17] = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359,
                           360, 361, 420, 480, 511};
        hsv_t c;
        foreach (hues[i])
        begin
            c.hue        = 9'(hues[i]);
            c.saturation = (i % 3 == 2) ? 8'd128 : 8'd255;
            c.brightness = (i % 4 == 3) ? 8'd200 : 8'd255;
            send_color(c, idle_len());
        end
        send_color('{hue: 9'd200, saturation: 8'd0,   brightness: 8'd255}, idle_len());
        send_color('{hue: 9'd90,  saturation: 8'd255, brightness: 8'd0},   idle_len());
        send_color('{hue: 9'd0,   saturation: 8'd0,   brightness: 8'd0},   idle_len());
        send_color('{hue: 9'd45,  saturation: 8'd1,   brightness: 8'd254}, idle_len());
        send_color('{hue: 9'd330, saturation: 8'd254, brightness: 8'd1},   idle_len());
    endtask

    task automatic test_random_colors(int count);
        for (int i = 0; i < count; i++)
        begin
            send_color(random_color(), ((i / 100) % 4 == 3) ? 0 : idle_len());
        end
    endtask

    task automatic test_back_to_back(int count);
        for (int i = 0; i < count; i++)
        begin
            send_color(random_color(), 0);
        end
        start <= 1'b0;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        while (pending_rgb.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (12) @(posedge clk);
        if (pending_rgb.size() != 0)
        begin
            report_fault($sformatf("%0d results never arrived", pending_rgb.size()));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_colors();
        test_random_colors(1500);
        test_back_to_back(200);
        drain_results();
        $display("Sent %0d colors across all six sectors, wrapped hues and channel extremes.",
                 colors_sent);
        $display("Checked %0d results, %0d failures.", colors_checked, fault_count);
        if (fault_count == 0)
        begin
            $display("tb_hsv_to_rgb_converter: done, clean");
        end
        else
        begin
            $display("tb_hsv_to_rgb_converter: done, errors");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Timed out with %0d results outstanding.", pending_rgb.size());
        $display("tb_hsv_to_rgb_converter: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hsvrgb_pkg.sv
sv/hsvrgb_sector.sv
sv/hsvrgb_terms.sv
sv/hsvrgb_select.sv
sv/hsv_to_rgb_converter.sv
tb/sv/tb_hsv_to_rgb_converter.sv
